// ===== src/spr_pkg.sv =====
// Shared types, codes and the CRC-8 step for the serial pad packet receiver.
`default_nettype none

package spr_pkg;

    // Link handshake states
    typedef enum logic [1:0] {
        LNK_SYNCED = 2'd0,
        LNK_START  = 2'd1,
        LNK_FIRST  = 2'd2,
        LNK_OUT    = 2'd3
    } link_state_t;

    // Reply byte kinds
    typedef enum logic [2:0] {
        KIND_SYNC_START = 3'd0,
        KIND_SYNC_1     = 3'd1,
        KIND_SYNC_OK    = 3'd2,
        KIND_ACK        = 3'd3,
        KIND_NACK       = 3'd4
    } reply_kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_START  = 2'd0;
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

    // Handshake code reset values
    localparam logic [7:0] SYNC_START_RST  = 8'hFF;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'h33;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hCC;

    localparam int          PAYLOAD_BYTES = 8;
    localparam logic [3:0]  PAYLOAD_LAST  = 4'd8;
    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [7:0]  AXIS_SMALL    = 8'h0F;
    localparam logic [7:0]  AXIS_RST      = 8'h80;
    localparam logic [3:0]  HAT_NEUTRAL   = 4'd8;

    // Control from the link controller to the report builder
    typedef struct packed {
        logic        store_we;
        logic [2:0]  store_idx;
        logic        report_fire;
        logic        reply_valid;
        reply_kind_t reply_kind;
    } link_ctrl_t;

    // Controller report fields
    typedef struct packed {
        logic [7:0]  right_y;
        logic [7:0]  right_x;
        logic [7:0]  left_y;
        logic [7:0]  left_x;
        logic [3:0]  hat;
        logic [15:0] buttons;
    } report_t;

    // One byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/spr_link_ctrl.sv =====
// Sync handshake state machine, payload byte counter and running CRC.
`default_nettype none

module spr_link_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [7:0]        start_code,
    input  wire logic [7:0]        first_code,
    input  wire logic [7:0]        second_code,
    output spr_pkg::link_ctrl_t    ctrl
);
    import spr_pkg::*;

    link_state_t state_reg, state_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;

    // Hold link state, byte count and CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LNK_OUT;
            count_reg <= 4'd0;
            crc_reg   <= 8'd0;
        end else if (advance) begin
            state_reg <= state_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // Decide next state and reply for the item at hand
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        ctrl.store_we    = 1'b0;
        ctrl.store_idx   = count_reg[2:0];
        ctrl.report_fire = 1'b0;
        ctrl.reply_valid = 1'b0;
        ctrl.reply_kind  = KIND_SYNC_START;
        case (state_reg)
            LNK_SYNCED: begin
                if (count_reg < PAYLOAD_LAST) begin
                    ctrl.store_we = 1'b1;
                    count_next    = count_reg + 4'd1;
                    crc_next      = crc8_step(crc_reg, rx_byte);
                end else begin
                    // Checksum byte: a match wins over the start code
                    ctrl.reply_valid = 1'b1;
                    if (crc_reg == rx_byte) begin
                        ctrl.reply_kind  = KIND_ACK;
                        ctrl.report_fire = 1'b1;
                    end else if (rx_byte == start_code) begin
                        state_next      = LNK_START;
                        ctrl.reply_kind = KIND_SYNC_START;
                    end else begin
                        ctrl.reply_kind = KIND_NACK;
                    end
                    count_next = 4'd0;
                    crc_next   = 8'd0;
                end
            end
            LNK_START: begin
                if (rx_byte == first_code) begin
                    state_next       = LNK_FIRST;
                    ctrl.reply_valid = 1'b1;
                    ctrl.reply_kind  = KIND_SYNC_1;
                end else if (rx_byte == start_code) begin
                    state_next       = LNK_START;
                    ctrl.reply_valid = 1'b1;
                end else begin
                    state_next = LNK_OUT;
                end
            end
            LNK_FIRST: begin
                if (rx_byte == second_code) begin
                    state_next       = LNK_SYNCED;
                    ctrl.reply_valid = 1'b1;
                    ctrl.reply_kind  = KIND_SYNC_OK;
                end else if (rx_byte == start_code) begin
                    state_next       = LNK_START;
                    ctrl.reply_valid = 1'b1;
                end else begin
                    state_next = LNK_OUT;
                end
            end
            default: begin
                // Out of sync: wait for the start code
                if (rx_byte == start_code) begin
                    state_next       = LNK_START;
                    ctrl.reply_valid = 1'b1;
                end else begin
                    state_next = LNK_OUT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/spr_report.sv =====
// Payload store, axis scaling and smoothing, and report formation.
`default_nettype none

module spr_report (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [7:0]        rx_byte,
    input  wire spr_pkg::link_ctrl_t ctrl,
    output spr_pkg::report_t       report
);
    import spr_pkg::*;

    logic [7:0] payload_reg [PAYLOAD_BYTES];
    logic [7:0] axes_reg    [4];
    logic [7:0] axes_next   [4];
    logic       small_axes;

    // Write payload bytes as they arrive
    always_ff @(posedge aclk) begin
        if (advance && ctrl.store_we) begin
            payload_reg[ctrl.store_idx] <= rx_byte;
        end
    end

    // Scale small axes up and average with the previous axes
    always_comb begin
        logic [7:0] raw;
        logic [8:0] sum;
        small_axes = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (payload_reg[3 + k] > AXIS_SMALL) begin
                small_axes = 1'b0;
            end
        end
        for (int k = 0; k < 4; k++) begin
            raw = small_axes ? {payload_reg[3 + k][3:0], 4'b0000} : payload_reg[3 + k];
            sum = {1'b0, axes_reg[k]} + {1'b0, raw};
            axes_next[k] = sum[8:1];
        end
    end

    // Keep the last smoothed axes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                axes_reg[k] <= AXIS_RST;
            end
        end else if (advance && ctrl.report_fire) begin
            for (int k = 0; k < 4; k++) begin
                axes_reg[k] <= axes_next[k];
            end
        end
    end

    // Form the report, zero when no report is due
    always_comb begin
        report = '0;
        if (ctrl.report_fire) begin
            report.buttons = {payload_reg[0], payload_reg[1]};
            report.hat     = (payload_reg[2] <= {4'd0, HAT_NEUTRAL}) ?
                             payload_reg[2][3:0] : HAT_NEUTRAL;
            report.left_x  = axes_next[0];
            report.left_y  = axes_next[1];
            report.right_x = axes_next[2];
            report.right_y = axes_next[3];
        end
    end

endmodule

`default_nettype wire

// ===== src/serial_pad_packet_receiver.sv =====
// Top level of the serial pad packet receiver: item registers and config.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata: rx_byte
//  m_       out  m_tvalid/m_tready   m_tuser: reply flags, m_tdata: report
//  cfg_     in   cfg_wr_en           cfg_index, cfg_data
//
// One byte is taken per cycle unless the result output stalls; each byte yields one
// result item: the byte passes the input register, then the state update and result register.
// Reset (aresetn low at a clock edge) drops the link out of sync, clears the
// count and CRC, sets the axes to mid scale and restores the handshake codes.
// A stalled result holds in the output register; the input register still
// takes one byte behind it, then s_tready falls until m_tready returns.
`default_nettype none

module serial_pad_packet_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [4:0]       m_tuser,   // [0] reply_valid, [3:1] reply_kind, [4] report_valid
    output logic [55:0]      m_tdata,   // [15:0] buttons, [19:16] hat, [27:20] left_x,
                                        // [35:28] left_y, [43:36] right_x, [51:44] right_y
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import spr_pkg::*;

    logic [7:0]  start_code_reg, first_code_reg, second_code_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [4:0]  out_user_reg;
    logic [55:0] out_data_reg;
    logic        advance;
    link_ctrl_t  ctrl;
    report_t     report;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg  <= SYNC_START_RST;
            first_code_reg  <= SYNC_FIRST_RST;
            second_code_reg <= SYNC_SECOND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SYNC_START:  start_code_reg  <= cfg_data;
                CFG_SYNC_FIRST:  first_code_reg  <= cfg_data;
                CFG_SYNC_SECOND: second_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the held item when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    spr_link_ctrl u_link_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .rx_byte     (in_byte_reg),
        .start_code  (start_code_reg),
        .first_code  (first_code_reg),
        .second_code (second_code_reg),
        .ctrl        (ctrl)
    );

    spr_report u_report (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .ctrl    (ctrl),
        .report  (report)
    );

    // Result item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_user_reg <= {ctrl.report_fire, ctrl.reply_kind, ctrl.reply_valid};
            out_data_reg <= {4'd0, report};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the serial pad packet receiver: drives bytes, predicts and checks every result.

module testbench;
    import spr_pkg::*;

    // How the checksum byte of a frame is chosen
    typedef enum int {
        CHK_GOOD,
        CHK_BAD,
        CHK_START
    } check_byte_t;

    // Receiver stall patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } ready_mode_t;

    // One expected result item
    typedef struct packed {
        logic            reply_valid;
        logic [2:0]      reply_kind;
        logic            report_valid;
        logic [15:0]     buttons;
        logic [3:0]      hat;
        logic [3:0][7:0] axis;      // left_x, left_y, right_x, right_y
    } pad_result_t;

    // Tracks the link and report state and holds the results still due
    class pad_scoreboard;
        logic [7:0]      start_code;
        logic [7:0]      first_code;
        logic [7:0]      second_code;
        link_state_t     link;
        logic [3:0]      count;
        logic [7:0]      crc;
        logic [7:0]      payload [PAYLOAD_BYTES];
        logic [3:0][7:0] prev_axis;
        pad_result_t     results_due [$];
        int              errors;

        function new();
            int k;
            start_code  = SYNC_START_RST;
            first_code  = SYNC_FIRST_RST;
            second_code = SYNC_SECOND_RST;
            link        = LNK_OUT;
            count       = '0;
            crc         = '0;
            errors      = 0;
            for (k = 0; k < 4; k++) begin
                prev_axis[k] = AXIS_RST;
            end
        endfunction

        // Serial CRC-8: shift the data in MSB first, feed back on the top bit
        function logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] data);
            logic [7:0] r;
            int i;
            r = acc;
            for (i = 7; i >= 0; i--) begin
                if (r[7] ^ data[i]) begin
                    r = {r[6:0], 1'b0} ^ CRC_POLY;
                end else begin
                    r = {r[6:0], 1'b0};
                end
            end
            return r;
        endfunction

        // Advance the link by one accepted byte and queue the result it causes
        function void note_input(logic [7:0] b);
            pad_result_t r;
            logic        all_small;
            logic [7:0]  ax;
            logic [8:0]  sum;
            int          k;
            r = '0;
            case (link)
                LNK_SYNCED: begin
                    if (count < PAYLOAD_LAST) begin
                        payload[count[2:0]] = b;
                        count = count + 4'd1;
                        crc = crc8_next(crc, b);
                    end else begin
                        r.reply_valid = 1'b1;
                        if (crc == b) begin
                            r.reply_kind   = KIND_ACK;
                            r.report_valid = 1'b1;
                            r.buttons      = {payload[0], payload[1]};
                            r.hat = (payload[2] <= {4'd0, HAT_NEUTRAL}) ?
                                    payload[2][3:0] : HAT_NEUTRAL;
                            all_small = 1'b1;
                            for (k = 0; k < 4; k++) begin
                                if (payload[3 + k] > AXIS_SMALL) begin
                                    all_small = 1'b0;
                                end
                            end
                            for (k = 0; k < 4; k++) begin
                                ax = all_small ? {payload[3 + k][3:0], 4'h0} : payload[3 + k];
                                sum = {1'b0, prev_axis[k]} + {1'b0, ax};
                                prev_axis[k] = sum[8:1];
                                r.axis[k] = sum[8:1];
                            end
                        end else if (b == start_code) begin
                            link         = LNK_START;
                            r.reply_kind = KIND_SYNC_START;
                        end else begin
                            r.reply_kind = KIND_NACK;
                        end
                        count = '0;
                        crc   = '0;
                    end
                end
                LNK_START: begin
                    if (b == first_code) begin
                        link          = LNK_FIRST;
                        r.reply_valid = 1'b1;
                        r.reply_kind  = KIND_SYNC_1;
                    end else begin
                        link = LNK_OUT;
                    end
                end
                LNK_FIRST: begin
                    if (b == second_code) begin
                        link          = LNK_SYNCED;
                        r.reply_valid = 1'b1;
                        r.reply_kind  = KIND_SYNC_OK;
                    end else begin
                        link = LNK_OUT;
                    end
                end
                default: begin
                    link = LNK_OUT;
                end
            endcase
            // A start code restarts the handshake from out of sync
            if (link == LNK_OUT && b == start_code) begin
                link          = LNK_START;
                r.reply_valid = 1'b1;
                r.reply_kind  = KIND_SYNC_START;
            end
            results_due.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < 50) begin
                $display("mismatch at %0t: %s", $time, msg);
            end
            errors++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
            end
        endtask

        // Compare one accepted result item with the oldest expectation
        task check_result(logic [4:0] tuser, logic [55:0] tdata);
            pad_result_t want;
            if (results_due.size() == 0) begin
                report_mismatch("result item with nothing expected");
                return;
            end
            want = results_due.pop_front();
            check_field("reply_valid", 16'(tuser[0]), 16'(want.reply_valid));
            check_field("reply_kind", 16'(tuser[3:1]), 16'(want.reply_kind));
            check_field("report_valid", 16'(tuser[4]), 16'(want.report_valid));
            check_field("buttons", tdata[15:0], want.buttons);
            check_field("hat", 16'(tdata[19:16]), 16'(want.hat));
            check_field("left_x", 16'(tdata[27:20]), 16'(want.axis[0]));
            check_field("left_y", 16'(tdata[35:28]), 16'(want.axis[1]));
            check_field("right_x", 16'(tdata[43:36]), 16'(want.axis[2]));
            check_field("right_y", 16'(tdata[51:44]), 16'(want.axis[3]));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [4:0]  m_tuser;   // [0] reply_valid, [3:1] reply_kind, [4] report_valid
    logic [55:0] m_tdata;   // [15:0] buttons, [19:16] hat, [27:20] left_x, [35:28] left_y,
                            // [43:36] right_x, [51:44] right_y
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_SYNC_START;
    logic [7:0]  cfg_data  = '0;

    pad_scoreboard sb = new();

    int          burst_left = 0;
    int          items_sent = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_left = 0;
    int          cyc        = 0;

    serial_pad_packet_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Check accepted results, then pick the next ready level from the stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata);
        end
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(10, 80);
        end
        ready_left--;
        cyc++;
        case (ready_mode)
            RDY_ALWAYS:   m_tready <= 1'b1;
            RDY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY:   m_tready <= ($urandom_range(0, 9) < 3);
            default:      m_tready <= (cyc % 4 != 0);
        endcase
    end

    // Offer one byte, idling between bursts, and hold it until accepted
    task automatic offer_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_input(b);
        items_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Write all three handshake codes in turn
    task automatic set_codes(input logic [7:0] start_v, input logic [7:0] first_v,
                             input logic [7:0] second_v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SYNC_START;
        cfg_data  <= start_v;
        @(posedge aclk);
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= first_v;
        @(posedge aclk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= second_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.start_code  = start_v;
        sb.first_code  = first_v;
        sb.second_code = second_v;
    endtask

    // Stop sending and wait until every expected result has come out
    task automatic wait_idle();
        int waited;
        stop_sending();
        waited = 0;
        while (sb.results_due.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_handshake();
        offer_byte(sb.start_code);
        offer_byte(sb.first_code);
        offer_byte(sb.second_code);
    endtask

    // Send eight payload bytes (byte 0 in the low bits) and a checksum byte
    task automatic send_frame(input logic [63:0] frame, input check_byte_t how);
        logic [7:0] sum;
        logic [7:0] chk;
        int         k;
        sum = '0;
        for (k = 0; k < PAYLOAD_BYTES; k++) begin
            offer_byte(frame[8 * k +: 8]);
            sum = sb.crc8_next(sum, frame[8 * k +: 8]);
        end
        case (how)
            CHK_GOOD:  chk = sum;
            CHK_START: chk = sb.start_code;
            default: begin
                do chk = 8'($urandom); while (chk == sum || chk == sb.start_code);
            end
        endcase
        offer_byte(chk);
    endtask

    function automatic logic [63:0] random_frame();
        logic [63:0] f;
        int          k;
        f = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1) begin
            f[23:16] = 8'($urandom_range(0, 8));
        end
        // Small axes get scaled before smoothing
        if ($urandom_range(0, 9) < 3) begin
            for (k = 3; k < 7; k++) begin
                f[8 * k +: 8] = 8'($urandom_range(0, 15));
            end
        end
        return f;
    endfunction

    // Mostly handshakes and frames with random content, some noise and broken handshakes
    task automatic random_traffic(input int n);
        int          stop_at;
        int          r;
        check_byte_t how;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                offer_byte(8'($urandom));
            end else if (sb.link != LNK_SYNCED) begin
                if (r < 14) begin
                    offer_byte(sb.start_code);
                    offer_byte(8'($urandom));
                end else if (r < 20) begin
                    offer_byte(sb.start_code);
                    offer_byte(sb.first_code);
                    offer_byte(8'($urandom));
                end else begin
                    send_handshake();
                end
            end else begin
                r = $urandom_range(0, 99);
                how = (r < 75) ? CHK_GOOD : (r < 88) ? CHK_BAD : CHK_START;
                send_frame(random_frame(), how);
            end
        end
    endtask

    initial begin
        logic [63:0] frame;
        logic [7:0]  frame_sum;
        logic [7:0]  code;
        int          k;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Handshake with drops at each stage and a restart on a repeated start code
        offer_byte(SYNC_START_RST);
        offer_byte(8'h12);
        offer_byte(SYNC_START_RST);
        offer_byte(SYNC_START_RST);
        offer_byte(SYNC_FIRST_RST);
        offer_byte(8'h00);
        send_handshake();
        // Good frame: full buttons, clamped hat, small axes
        send_frame(64'hAA_05_0F_00_0F_09_FF_FF, CHK_GOOD);
        // Bad checksum that is the start code restarts the handshake
        send_frame(64'h55_00_10_80_FF_08_00_00, CHK_START);
        wait_idle();

        // Start code equal to a frame's checksum: the match wins
        frame = 64'h00_00_10_80_FF_00_00_00;
        frame_sum = '0;
        for (k = 0; k < PAYLOAD_BYTES; k++) begin
            frame_sum = sb.crc8_next(frame_sum, frame[8 * k +: 8]);
        end
        set_codes(frame_sum, 8'h00, 8'hFF);
        send_handshake();
        send_frame(frame, CHK_GOOD);
        send_frame(random_frame(), CHK_BAD);
        random_traffic(100);
        wait_idle();

        set_codes(8'h00, 8'hFF, 8'h00);
        random_traffic(100);
        wait_idle();

        set_codes(8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(100);
        wait_idle();

        // All three codes the same
        code = 8'($urandom);
        set_codes(code, code, code);
        random_traffic(80);
        wait_idle();

        set_codes(SYNC_START_RST, SYNC_FIRST_RST, SYNC_SECOND_RST);
        random_traffic(100);
        wait_idle();

        if (sb.results_due.size() != 0) begin
            sb.report_mismatch($sformatf("%0d expected results never came",
                                         sb.results_due.size()));
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/spr_pkg.sv
src/spr_link_ctrl.sv
src/spr_report.sv
src/serial_pad_packet_receiver.sv
tb/testbench.sv
